// File: src/esc_utf8_pkg.sv
// Shared types and constants for the escape-sequence to UTF-8 resolver.
// Depends on nothing; imported by the front end, queue, back end, top level and testbench.
package esc_utf8_pkg;

    // Error codes carried on the result channel's tuser.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LETTER = 3'd1;
    localparam logic [2:0] ERR_TRAIL_BSL  = 3'd2;
    localparam logic [2:0] ERR_HEX_COUNT  = 3'd3;
    localparam logic [2:0] ERR_CODEPOINT  = 3'd4;

    // Depth of the command queue between front and back end.
    localparam int QDEPTH = 2;

    // One command: the result items caused by one input transaction.
    // Up to four code point bytes, then optionally one tail item (a plain byte,
    // a simple escape or an error item).
    typedef struct packed {
        logic [3:0][7:0] cp_bytes;   // code point bytes, index 0 emitted first
        logic [2:0]      cp_n;       // number of code point bytes, 0 to 4
        logic            tail_vld;   // a tail item follows the code point bytes
        logic [7:0]      tail_byte;  // tail byte, zero for an error item
        logic [2:0]      tail_err;   // error code of the tail item
        logic            last;       // final item of the command closes the string
    } cmd_t;

endpackage

// File: src/esc_utf8_front.sv
// Front end of the resolver: accepts input bytes, tracks the escape parser state
// and turns each byte that yields results into a command. Depends on esc_utf8_pkg.
module esc_utf8_front
    import esc_utf8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_acc,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       cmd_push,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    mode_t       mode_reg, mode_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic        drop_reg, drop_next;

    // Returns {is_digit, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Returns {is_simple_escape, byte}.
    function automatic logic [8:0] simple_esc(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h5C:   r = {1'b1, 8'h5C};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            8'h30:   r = {1'b1, 8'h00};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic [4:0]  hd;
    logic        is_hex;
    logic [31:0] acc_new;
    logic [3:0]  cnt_new;
    logic [31:0] fin_acc;
    logic [3:0]  fin_cnt;
    logic [2:0]  fin_err;
    logic [3:0][7:0] enc_bytes;
    logic [2:0]  enc_n;
    logic [8:0]  se;

    assign hd      = hex_digit(in_byte);
    assign is_hex  = hd[4];
    assign acc_new = {acc_reg[27:0], hd[3:0]};
    assign cnt_new = cnt_reg + 4'd1;
    assign se      = simple_esc(in_byte);

    // The run is finished either with the new digit joined (last byte is a digit)
    // or as it stood (a non-digit ends it).
    assign fin_acc = is_hex ? acc_new : acc_reg;
    assign fin_cnt = is_hex ? cnt_new : cnt_reg;

    always_comb begin
        fin_err   = ERR_NONE;
        enc_bytes = '0;
        enc_n     = 3'd0;
        if (fin_cnt != 4'd4 && fin_cnt != 4'd8) begin
            fin_err = ERR_HEX_COUNT;
        end else if (fin_acc > 32'h0010_FFFF ||
                     (fin_acc >= 32'h0000_D800 && fin_acc <= 32'h0000_DFFF)) begin
            fin_err = ERR_CODEPOINT;
        end else if (fin_acc <= 32'h0000_007F) begin
            enc_bytes[0] = fin_acc[7:0];
            enc_n        = 3'd1;
        end else if (fin_acc <= 32'h0000_07FF) begin
            enc_bytes[0] = {3'b110, fin_acc[10:6]};
            enc_bytes[1] = {2'b10, fin_acc[5:0]};
            enc_n        = 3'd2;
        end else if (fin_acc <= 32'h0000_FFFF) begin
            enc_bytes[0] = {4'b1110, fin_acc[15:12]};
            enc_bytes[1] = {2'b10, fin_acc[11:6]};
            enc_bytes[2] = {2'b10, fin_acc[5:0]};
            enc_n        = 3'd3;
        end else begin
            enc_bytes[0] = {5'b11110, fin_acc[20:18]};
            enc_bytes[1] = {2'b10, fin_acc[17:12]};
            enc_bytes[2] = {2'b10, fin_acc[11:6]};
            enc_bytes[3] = {2'b10, fin_acc[5:0]};
            enc_n        = 3'd4;
        end
    end

    logic [2:0] err;
    logic       run_text;
    logic       as_esc;
    logic       do_fin;

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        drop_next = drop_reg;
        cmd       = '0;
        cmd_push  = 1'b0;
        err       = ERR_NONE;
        run_text  = 1'b0;
        as_esc    = (mode_reg == MODE_ESC);
        do_fin    = 1'b0;
        if (in_acc) begin
            if (drop_reg) begin
                if (in_last) begin
                    drop_next = 1'b0;
                end
            end else begin
                run_text = 1'b1;
                if (mode_reg == MODE_HEX) begin
                    if (is_hex) begin
                        run_text = 1'b0;
                        if (cnt_reg == 4'd8) begin
                            err = ERR_HEX_COUNT;
                        end else if (in_last) begin
                            do_fin = 1'b1;
                        end else begin
                            acc_next = acc_new;
                            cnt_next = cnt_new;
                        end
                    end else begin
                        do_fin = 1'b1;
                        as_esc = 1'b0;
                    end
                end
                if (do_fin) begin
                    if (fin_err != ERR_NONE) begin
                        err      = fin_err;
                        run_text = 1'b0;
                    end else begin
                        cmd.cp_bytes = enc_bytes;
                        cmd.cp_n     = enc_n;
                        mode_next    = MODE_NORMAL;
                        cnt_next     = 4'd0;
                        acc_next     = 32'd0;
                    end
                end
                if (run_text) begin
                    if (as_esc) begin
                        if (in_byte == CH_LOW_U || in_byte == CH_UP_U) begin
                            mode_next = MODE_HEX;
                            cnt_next  = 4'd0;
                            acc_next  = 32'd0;
                            if (in_last) begin
                                err = ERR_HEX_COUNT;
                            end
                        end else if (se[8]) begin
                            cmd.tail_vld  = 1'b1;
                            cmd.tail_byte = se[7:0];
                            mode_next     = MODE_NORMAL;
                        end else begin
                            err = ERR_BAD_LETTER;
                        end
                    end else if (in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                        if (in_last) begin
                            err = ERR_TRAIL_BSL;
                        end
                    end else begin
                        cmd.tail_vld  = 1'b1;
                        cmd.tail_byte = in_byte;
                    end
                end
                if (err != ERR_NONE) begin
                    // Error item closes the string; earlier code point bytes stay.
                    cmd.tail_vld  = 1'b1;
                    cmd.tail_byte = 8'd0;
                    cmd.tail_err  = err;
                    cmd.last      = 1'b1;
                    drop_next     = !in_last;
                end else begin
                    cmd.last = in_last;
                end
                if (err != ERR_NONE || in_last) begin
                    mode_next = MODE_NORMAL;
                    cnt_next  = 4'd0;
                    acc_next  = 32'd0;
                end
                cmd_push = (cmd.cp_n != 3'd0) || cmd.tail_vld;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 4'd0;
            acc_reg  <= 32'd0;
            drop_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// File: src/esc_utf8_queue.sv
// Short command queue that decouples the resolver's front end from its back end.
// Depends on esc_utf8_pkg for the command type and the queue depth.
module esc_utf8_queue
    import esc_utf8_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          entry_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(QDEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/esc_utf8_back.sv
// Back end of the resolver: holds one command and issues its result items one per cycle while out_rdy is high.
// Depends on esc_utf8_pkg for the command type.
module esc_utf8_back
    import esc_utf8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head_cmd,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_vld,
    input  logic       out_rdy,
    output logic [7:0] out_byte,
    output logic       out_end,
    output logic [2:0] out_err
);

    cmd_t       cur_reg, cur_next;
    logic       vld_reg, vld_next;
    logic [2:0] idx_reg, idx_next;

    logic [2:0] n_items;
    logic       at_final;
    logic       in_cp;
    logic       done;

    assign n_items  = cur_reg.cp_n + {2'b00, cur_reg.tail_vld};
    assign at_final = (idx_reg == n_items - 3'd1);
    assign in_cp    = (idx_reg < cur_reg.cp_n);
    assign done     = vld_reg && out_rdy && at_final;

    assign out_vld  = vld_reg;
    assign out_byte = in_cp ? cur_reg.cp_bytes[idx_reg[1:0]] : cur_reg.tail_byte;
    assign out_err  = in_cp ? ERR_NONE : cur_reg.tail_err;
    assign out_end  = cur_reg.last && at_final;

    assign q_pop = (!vld_reg || done) && !q_empty;

    always_comb begin
        cur_next = cur_reg;
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (!vld_reg || done) begin
            vld_next = !q_empty;
            cur_next = head_cmd;
            idx_next = 3'd0;
        end else if (out_rdy) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 3'd0;
        end else begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

// File: src/escape_sequence_to_utf8_resolver.sv
// Top level of the escape-sequence to UTF-8 resolver.
// Depends on esc_utf8_pkg, esc_utf8_front, esc_utf8_queue and esc_utf8_back.
//
//   Channel | Direction | tdata          | tlast    | tuser
//   --------+-----------+----------------+----------+-----------------
//   s_      | input     | [7:0] in_byte  | in_last  | -
//   m_      | output    | [7:0] out_byte | out_end  | [2:0] err_code
//
// Each input transaction is parsed in the cycle it is accepted and may leave a
// command in a two-entry queue; the back end then issues its result items at one
// per cycle while m_tready is high: one for a byte, one to four for a code point,
// plus one more when the byte that ends its hex run yields a result of its own.
// A command is registered in the queue, then in the back end. A byte that yields
// several results holds the queue, and s_tready falls only when the queue is full.
// Reset (aresetn low, synchronous) clears the parser state, the queue and the back
// end; payload registers are not reset. Either side may stall at any time without
// loss or repetition.
module escape_sequence_to_utf8_resolver
    import esc_utf8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel: one byte of the string literal body per transaction.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last: final byte of the literal
    // Result channel: one resolved UTF-8 byte or one error item per transaction.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte, zero in an error item
    output logic       m_tlast,   // out_end: last result of the string
    output logic [2:0] m_tuser    // [2:0] err_code
);

    logic in_acc;
    logic cmd_push;
    cmd_t cmd;
    cmd_t head_cmd;
    logic q_pop, q_empty, q_full;

    // The front end parses every accepted byte combinationally, so it is ready
    // whenever the queue has room for the command it may produce.
    assign s_tready = !q_full;
    assign in_acc   = s_tvalid && s_tready;

    esc_utf8_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_acc   (in_acc),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    esc_utf8_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The back end serialises each command into result transactions.
    esc_utf8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_vld  (m_tvalid),
        .out_rdy  (m_tready),
        .out_byte (m_tdata),
        .out_end  (m_tlast),
        .out_err  (m_tuser)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the escape-sequence to UTF-8 resolver.
// Depends on esc_utf8_pkg, the resolver top level and its submodules; needs nothing else.
`timescale 1ns / 100ps

module testbench;
    import esc_utf8_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES = 150;
    localparam logic [7:0] BACKSLASH = 8'h5C;

    // Where the predictor stands inside a literal.
    typedef enum logic [1:0] {PM_TEXT, PM_ESCAPE, PM_HEX, PM_UNUSED} parse_mode_t;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [2:0] err;
    } utf8_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    // Predictor state, a private copy of the parser inside the block.
    parse_mode_t pmode = PM_TEXT;
    logic [3:0]  digit_count = 4'd0;
    logic [31:0] cp_accum = 32'd0;
    logic        dropping = 1'b0;
    int          step_count;

    utf8_item_t  expected_q[$];
    logic [7:0]  text_buf[$];
    string       escape_letters = "\\'\"abfnrtv0";
    string       bad_letters = "qxzcdeghIK9?";

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    logic hold_off = 1'b0;

    int cycle_count = 0;
    int mismatches = 0;
    int strings_sent = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int error_items_seen = 0;

    escape_sequence_to_utf8_resolver DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // A run that cannot finish within the limit counts as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls at random, and throughout while a hold-off is in force.
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b);
        utf8_item_t item;
        item.data = b;
        item.fin = 1'b0;
        item.err = ERR_NONE;
        expected_q.push_back(item);
        step_count++;
    endtask

    task automatic clear_parser();
        pmode = PM_TEXT;
        digit_count = 4'd0;
        cp_accum = 32'd0;
        dropping = 1'b0;
    endtask

    // Closes a \u or \U run: checks the digit count and the code point, and on
    // success queues the code point as one to four UTF-8 bytes.
    task automatic close_hex_run(output logic [2:0] code);
        code = ERR_NONE;
        if (digit_count != 4'd4 && digit_count != 4'd8) begin
            code = ERR_HEX_COUNT;
        end else if (cp_accum > 32'h10FFFF || (cp_accum >= 32'hD800 && cp_accum <= 32'hDFFF)) begin
            code = ERR_CODEPOINT;
        end else begin
            if (cp_accum <= 32'h7F) begin
                put_byte(cp_accum[7:0]);
            end else if (cp_accum <= 32'h7FF) begin
                put_byte({3'b110, cp_accum[10:6]});
                put_byte({2'b10, cp_accum[5:0]});
            end else if (cp_accum <= 32'hFFFF) begin
                put_byte({4'b1110, cp_accum[15:12]});
                put_byte({2'b10, cp_accum[11:6]});
                put_byte({2'b10, cp_accum[5:0]});
            end else begin
                put_byte({5'b11110, cp_accum[20:18]});
                put_byte({2'b10, cp_accum[17:12]});
                put_byte({2'b10, cp_accum[11:6]});
                put_byte({2'b10, cp_accum[5:0]});
            end
            pmode = PM_TEXT;
            digit_count = 4'd0;
            cp_accum = 32'd0;
        end
    endtask

    // Works out the results of one accepted input transaction and queues them.
    task automatic resolve_byte(input logic [7:0] b, input logic fin);
        logic [2:0] fault;
        logic       used;
        logic       is_digit;
        logic       known;
        logic [7:0] nib;
        logic [7:0] esc;
        utf8_item_t item;
        fault = ERR_NONE;
        used = 1'b0;
        step_count = 0;
        if (dropping) begin
            // After an error the rest of the literal is swallowed.
            if (fin) clear_parser();
            return;
        end
        if (pmode == PM_UNUSED) pmode = PM_TEXT;

        if (pmode == PM_HEX) begin
            is_digit = 1'b1;
            nib = 8'd0;
            if (b >= "0" && b <= "9") nib = b - "0";
            else if (b >= "a" && b <= "f") nib = b - "a" + 8'd10;
            else if (b >= "A" && b <= "F") nib = b - "A" + 8'd10;
            else is_digit = 1'b0;
            if (is_digit) begin
                used = 1'b1;
                cp_accum = {cp_accum[27:0], nib[3:0]};
                digit_count = digit_count + 4'd1;
                if (digit_count >= 4'd9) fault = ERR_HEX_COUNT;
                else if (fin) close_hex_run(fault);
            end else begin
                // A non-hex byte ends the run and is then read as ordinary text.
                close_hex_run(fault);
            end
        end

        if (fault == ERR_NONE && !used) begin
            if (pmode == PM_ESCAPE) begin
                if (b == "u" || b == "U") begin
                    pmode = PM_HEX;
                    digit_count = 4'd0;
                    cp_accum = 32'd0;
                    if (fin) fault = ERR_HEX_COUNT;
                end else begin
                    known = 1'b1;
                    esc = 8'h00;
                    case (b)
                        "\\":    esc = 8'h5C;
                        "'":     esc = 8'h27;
                        "\"":    esc = 8'h22;
                        "a":     esc = 8'h07;
                        "b":     esc = 8'h08;
                        "f":     esc = 8'h0C;
                        "n":     esc = 8'h0A;
                        "r":     esc = 8'h0D;
                        "t":     esc = 8'h09;
                        "v":     esc = 8'h0B;
                        "0":     esc = 8'h00;
                        default: known = 1'b0;
                    endcase
                    if (!known) begin
                        fault = ERR_BAD_LETTER;
                    end else begin
                        put_byte(esc);
                        pmode = PM_TEXT;
                    end
                end
            end else if (b == BACKSLASH) begin
                pmode = PM_ESCAPE;
                if (fin) fault = ERR_TRAIL_BSL;
            end else begin
                put_byte(b);
            end
        end

        if (fault != ERR_NONE) begin
            // Results already produced by this byte stay; the error item closes the string.
            item.data = 8'h00;
            item.fin = 1'b1;
            item.err = fault;
            expected_q.push_back(item);
            clear_parser();
            dropping = !fin;
        end else if (fin) begin
            if (step_count > 0) begin
                item = expected_q.pop_back();
                item.fin = 1'b1;
                expected_q.push_back(item);
            end
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transaction, checks every result.
    // Both channels are sampled at the rising edge, before any of this
    // edge's updates, and prediction comes first within the same edge.
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        utf8_item_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) resolve_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser != ERR_NONE) error_items_seen++;
                if (expected_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: byte %02h end %0b err %0d",
                                           m_tdata, m_tlast, m_tuser));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.fin || m_tuser !== want.err)
                        note_failure($sformatf(
                            "result differs: got byte %02h end %0b err %0d, want %02h %0b %0d",
                            m_tdata, m_tlast, m_tuser, want.data, want.fin, want.err));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where the transaction is accepted.
    // The valid is only dropped when the sender decides to idle.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
        strings_sent++;
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // Appends the low digits of a value as hex text in mixed case.
    task automatic push_hex(input logic [31:0] value, input int ndigits);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int i = ndigits - 1; i >= 0; i--) begin
            nib = 4'(value >> (4 * i));
            if (nib < 4'd10) ch = "0" + {4'd0, nib};
            else ch = ($urandom_range(1) ? "a" : "A") + {4'd0, nib} - 8'd10;
            text_buf.push_back(ch);
        end
    endtask

    function automatic logic [31:0] random_code_point(input bit bmp_only);
        logic [31:0] cp;
        case ($urandom_range(bmp_only ? 2 : 3))
            0: cp = $urandom_range(32'h7F, 32'h0);
            1: cp = $urandom_range(32'h7FF, 32'h80);
            2: begin
                cp = $urandom_range(32'hFFFF, 32'h800);
                if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
            end
            default: cp = $urandom_range(32'h10FFFF, 32'h10000);
        endcase
        return cp;
    endfunction

    // Builds one literal from random tokens: mostly well formed, some broken.
    task automatic build_random_text();
        int     tokens;
        int     pick;
        logic [7:0] b;
        bit     ended;
        tokens = $urandom_range(6, 1);
        ended = 0;
        for (int t = 0; t < tokens && !ended; t++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                b = 8'($urandom_range(255));
                text_buf.push_back(b);
                if (b == BACKSLASH) text_buf.push_back(BACKSLASH);
            end else if (pick < 55) begin
                text_buf.push_back(BACKSLASH);
                text_buf.push_back(escape_letters[$urandom_range(escape_letters.len() - 1)]);
            end else if (pick < 75) begin
                text_buf.push_back(BACKSLASH);
                text_buf.push_back("u");
                push_hex(random_code_point(1), 4);
            end else if (pick < 87) begin
                text_buf.push_back(BACKSLASH);
                text_buf.push_back("U");
                push_hex(random_code_point(0), 8);
            end else begin
                text_buf.push_back(BACKSLASH);
                case ($urandom_range(5))
                    0: begin
                        if ($urandom_range(1))
                            text_buf.push_back(bad_letters[$urandom_range(bad_letters.len() - 1)]);
                        else
                            text_buf.push_back(8'($urandom_range(255, 128)));
                    end
                    1: begin
                        text_buf.push_back($urandom_range(1) ? "u" : "U");
                        pick = $urandom_range(7);
                        if (pick == 4) pick = 0;
                        push_hex($urandom, pick);
                    end
                    2: begin
                        text_buf.push_back("u");
                        push_hex($urandom_range(32'hDFFF, 32'hD800), 4);
                    end
                    3: begin
                        text_buf.push_back("U");
                        push_hex($urandom_range(32'hFFFFFFFF, 32'h110000), 8);
                    end
                    4: begin
                        text_buf.push_back("U");
                        push_hex($urandom, 8);
                        push_hex($urandom, 1);
                    end
                    default: ended = 1;
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain bytes at the ends of the range, including the ones next to 0x80.
    task automatic test_plain_bytes();
        text_buf = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'hA5, 8'h5A};
        send_text();
        send_literal("Z");
    endtask

    // Every single-letter escape once.
    task automatic test_simple_escapes();
        send_literal("\\\\\\'\\\"\\a\\b\\f\\n\\r\\t\\v\\0");
    endtask

    // Code points of every encoded length, and every way a hex run can end.
    task automatic test_code_points();
        send_literal("\\u0041");
        send_literal("\\u00e9\\n");
        send_literal("\\uaBcD!");
        send_literal("\\U0010FFFF");
        send_literal("\\U00000041\\u07FFx\\u0800\\U00010000");
        // A byte at or above 0x80 is never a hex digit and ends the run.
        text_buf = '{BACKSLASH, "u", "0", "0", "4", "1", 8'hC1};
        send_text();
    endtask

    // Each error kind, errors mid-string with the rest dropped, and recovery.
    task automatic test_error_cases();
        send_literal("\\q");
        send_literal("\\qab\\u12");
        send_literal("ab\\");
        send_literal("\\u12");
        send_literal("\\u12z");
        send_literal("\\U123456789rest");
        send_literal("\\u");
        send_literal("x\\U");
        send_literal("\\uD800");
        send_literal("\\uDFFFq");
        send_literal("\\U00110000");
        send_literal("\\UFFFFFFFF");
        send_literal("\\u12345");
        text_buf = '{BACKSLASH, 8'h80, "a"};
        send_text();
        send_literal("ok");
    endtask

    // The receiver holds off for a long stretch while four- and three-byte code points
    // arrive, so the block's queue fills and it must stall its input.
    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
            send_literal("\\U0001F600\\U0010FFFF\\u20ACend");
        join
    endtask

    task automatic test_random_mix(input int byte_budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget) begin
            build_random_text();
            send_text();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 35;
        sink_idle_pct = 64;
        test_plain_bytes();
        test_simple_escapes();
        test_code_points();
        test_error_cases();
        test_backpressure();

        src_idle_pct = 64;
        sink_idle_pct = 35;
        test_random_mix(6);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_mix(6);

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d literals (%0d bytes) under three idling patterns and a long hold-off;",
                 strings_sent, bytes_sent);
        $display("checked %0d results, %0d of them error items, with %0d mismatches.",
                 results_seen, error_items_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
